// ===== design/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg - shared types and constants of the first-fit heap allocator
// Header layout, status and command codes, sequencer states, memory request and adder bundles.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int REGION_BYTES = 16384;
    localparam int HEADER_BYTES = 32;
    localparam int GRAIN_BYTES  = 8;

    localparam int DEPTH  = REGION_BYTES / GRAIN_BYTES;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int SIZE_W = 14;
    localparam int OFF_W  = 14;
    localparam int REQ_W  = 16;
    localparam int ALU_W  = REQ_W + 2;
    localparam int GRAIN_SH = $clog2(GRAIN_BYTES);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [ALU_W-1:0] alu_word_t;

    typedef struct packed {
        logic              is_start;
        logic              is_free;
        logic              has_prev;
        logic              has_next;
        logic [SIZE_W-1:0] size;
        idx_t              prev_idx;
        idx_t              next_idx;
    } hdr_t;

    localparam hdr_t HDR_NONE = '0;
    localparam hdr_t HDR_INIT = '{
        is_start: 1'b1,
        is_free:  1'b1,
        has_prev: 1'b0,
        has_next: 1'b0,
        size:     SIZE_W'(REGION_BYTES - HEADER_BYTES),
        prev_idx: '0,
        next_idx: '0
    };

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_ZERO    = 3'd1,
        STAT_NOSPACE = 3'd2,
        STAT_NULL    = 3'd3,
        STAT_BADFREE = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_ROUND,
        S_A_NEEDH,
        S_A_READ,
        S_A_FIT,
        S_A_SPLIT,
        S_A_NB,
        S_A_WNB,
        S_A_WRN,
        S_A_MARK,
        S_F_SUB,
        S_F_READ,
        S_F_CHK,
        S_F_PCHK,
        S_F_PADD1,
        S_F_PADD2,
        S_F_NXT,
        S_F_NCHK,
        S_F_NADD1,
        S_F_NADD2,
        S_F_WRNN,
        S_F_WRW,
        S_DONE
    } state_t;

    typedef struct packed {
        logic we;
        idx_t waddr;
        hdr_t wdata;
        idx_t raddr;
    } mem_req_t;

    typedef struct packed {
        alu_word_t a;
        alu_word_t b;
        logic      sub;
    } alu_op_t;

    typedef struct packed {
        alu_word_t sum;
        logic      no_borrow;
    } alu_res_t;

endpackage

// ===== design/ffha_if.sv =====
// ----------------------------------------------------------------------------
// ffha_if - request and response channels of the heap allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] request_size;
    logic [13:0] user_offset;

    modport source (output valid, output command, output request_size,
                    output user_offset, input ready);
    modport sink   (input valid, input command, input request_size,
                    input user_offset, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [13:0] result_offset;
    logic [2:0]  status;

    modport source (output valid, output result_offset, output status, input ready);
    modport sink   (input valid, input result_offset, input status, output ready);
endinterface

// ===== design/ffha_hdr_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_hdr_ram - block header store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffha_hdr_ram
    import ffha_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output hdr_t     rdata
);

    hdr_t mem [DEPTH];
    hdr_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rdata_reg <= mem[mem_req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ffha_alu.sv =====
// ----------------------------------------------------------------------------
// ffha_alu - shared adder/subtractor
// Add or subtract; on subtract, no_borrow flags a >= b.
// ----------------------------------------------------------------------------
module ffha_alu
    import ffha_pkg::*;
(
    input  alu_op_t  op,
    output alu_res_t res
);

    logic [ALU_W:0] full;
    alu_word_t      b_eff;

    always_comb
    begin
        b_eff = op.sub ? ~op.b : op.b;
        full  = {1'b0, op.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, op.sub};
        res.sum       = full[ALU_W-1:0];
        res.no_borrow = full[ALU_W];
    end

endmodule

// ===== design/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl - allocator sequencer
// Walks the header chain, splits and merges blocks, drives the result beat.
// ----------------------------------------------------------------------------
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ffha_req_if.sink      req,
    ffha_rsp_if.source    rsp,
    output mem_req_t      mem_req,
    input  hdr_t          mem_rdata,
    output alu_op_t       alu_op,
    input  alu_res_t      alu_res
);

    state_t            state_reg, state_next;
    idx_t              clr_reg, clr_next;
    logic [REQ_W-1:0]  size_in_reg, size_in_next;
    logic [OFF_W-1:0]  uoff_reg, uoff_next;
    alu_word_t         need_reg, need_next;
    alu_word_t         needh_reg, needh_next;
    alu_word_t         tmp_reg, tmp_next;
    idx_t              idx_reg, idx_next;
    idx_t              nb_reg, nb_next;
    hdr_t              hdr_reg, hdr_next;
    hdr_t              oth_reg, oth_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic              split_reg, split_next;
    logic              moved_reg, moved_next;
    logic [OFF_W-1:0]  res_off_reg, res_off_next;
    status_t           res_st_reg, res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [OFF_W-1:0]  out_off_reg, out_off_next;
    status_t           out_st_reg, out_st_next;

    hdr_t      wr_hdr;
    alu_word_t idx_bytes;

    assign idx_bytes = ALU_W'({idx_reg, {GRAIN_SH{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_in_reg <= size_in_next;
        uoff_reg    <= uoff_next;
        need_reg    <= need_next;
        needh_reg   <= needh_next;
        tmp_reg     <= tmp_next;
        idx_reg     <= idx_next;
        nb_reg      <= nb_next;
        hdr_reg     <= hdr_next;
        oth_reg     <= oth_next;
        rem_reg     <= rem_next;
        split_reg   <= split_next;
        moved_reg   <= moved_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
        out_off_reg <= out_off_next;
        out_st_reg  <= out_st_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        size_in_next   = size_in_reg;
        uoff_next      = uoff_reg;
        need_next      = need_reg;
        needh_next     = needh_reg;
        tmp_next       = tmp_reg;
        idx_next       = idx_reg;
        nb_next        = nb_reg;
        hdr_next       = hdr_reg;
        oth_next       = oth_reg;
        rem_next       = rem_reg;
        split_next     = split_reg;
        moved_next     = moved_reg;
        res_off_next   = res_off_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_off_next   = out_off_reg;
        out_st_next    = out_st_reg;
        wr_hdr         = mem_rdata;

        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg;
        mem_req.wdata = hdr_reg;
        mem_req.raddr = idx_reg;

        alu_op.a   = '0;
        alu_op.b   = '0;
        alu_op.sub = 1'b0;

        req.ready = (state_reg == S_IDLE);

        // drop the result beat once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                mem_req.wdata = (clr_reg == '0) ? HDR_INIT : HDR_NONE;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == idx_t'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    size_in_next = req.request_size;
                    uoff_next    = req.user_offset;
                    res_off_next = '0;
                    if (req.command == CMD_ALLOC)
                    begin
                        if (req.request_size == '0)
                        begin
                            res_st_next = STAT_ZERO;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_A_ROUND;
                        end
                    end
                    else if (req.user_offset == '0)
                    begin
                        res_st_next = STAT_NULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_F_SUB;
                    end
                end
            end

            // ---------------- allocate ----------------
            S_A_ROUND:
            begin
                alu_op.a   = ALU_W'(size_in_reg);
                alu_op.b   = ALU_W'(GRAIN_BYTES - 1);
                need_next  = {alu_res.sum[ALU_W-1:GRAIN_SH], {GRAIN_SH{1'b0}}};
                state_next = S_A_NEEDH;
            end

            S_A_NEEDH:
            begin
                alu_op.a   = need_reg;
                alu_op.b   = ALU_W'(HEADER_BYTES);
                needh_next = alu_res.sum;
                idx_next   = '0;
                state_next = S_A_READ;
            end

            S_A_READ:
            begin
                state_next = S_A_FIT;
            end

            S_A_FIT:
            begin
                alu_op.a   = ALU_W'(mem_rdata.size);
                alu_op.b   = need_reg;
                alu_op.sub = 1'b1;
                if (mem_rdata.is_free && alu_res.no_borrow)
                begin
                    hdr_next   = mem_rdata;
                    state_next = S_A_SPLIT;
                end
                else if (mem_rdata.has_next)
                begin
                    idx_next   = mem_rdata.next_idx;
                    state_next = S_A_READ;
                end
                else
                begin
                    res_st_next = STAT_NOSPACE;
                    state_next  = S_DONE;
                end
            end

            S_A_SPLIT:
            begin
                alu_op.a   = ALU_W'(hdr_reg.size);
                alu_op.b   = needh_reg;
                alu_op.sub = 1'b1;
                rem_next   = alu_res.sum[SIZE_W-1:0];
                split_next = alu_res.no_borrow && (alu_res.sum != '0);
                state_next = (alu_res.no_borrow && (alu_res.sum != '0)) ? S_A_NB : S_A_MARK;
            end

            S_A_NB:
            begin
                alu_op.a   = idx_bytes;
                alu_op.b   = needh_reg;
                nb_next    = alu_res.sum[GRAIN_SH +: IDX_W];
                state_next = S_A_WNB;
            end

            S_A_WNB:
            begin
                mem_req.we            = 1'b1;
                mem_req.waddr         = nb_reg;
                mem_req.wdata         = HDR_NONE;
                mem_req.wdata.is_start = 1'b1;
                mem_req.wdata.is_free  = 1'b1;
                mem_req.wdata.has_prev = 1'b1;
                mem_req.wdata.has_next = hdr_reg.has_next;
                mem_req.wdata.size     = rem_reg;
                mem_req.wdata.prev_idx = idx_reg;
                mem_req.wdata.next_idx = hdr_reg.next_idx;
                // fetch the old successor to relink its back pointer
                mem_req.raddr         = hdr_reg.next_idx;
                state_next            = hdr_reg.has_next ? S_A_WRN : S_A_MARK;
            end

            S_A_WRN:
            begin
                wr_hdr.prev_idx = nb_reg;
                mem_req.we      = 1'b1;
                mem_req.waddr   = hdr_reg.next_idx;
                mem_req.wdata   = wr_hdr;
                state_next      = S_A_MARK;
            end

            S_A_MARK:
            begin
                wr_hdr         = hdr_reg;
                wr_hdr.is_free = 1'b0;
                if (split_reg)
                begin
                    wr_hdr.size     = need_reg[SIZE_W-1:0];
                    wr_hdr.has_next = 1'b1;
                    wr_hdr.next_idx = nb_reg;
                end
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                mem_req.wdata = wr_hdr;
                alu_op.a      = idx_bytes;
                alu_op.b      = ALU_W'(HEADER_BYTES);
                res_off_next  = alu_res.sum[OFF_W-1:0];
                res_st_next   = STAT_OK;
                state_next    = S_DONE;
            end

            // ---------------- free ----------------
            S_F_SUB:
            begin
                alu_op.a   = ALU_W'(uoff_reg);
                alu_op.b   = ALU_W'(HEADER_BYTES);
                alu_op.sub = 1'b1;
                idx_next   = alu_res.sum[GRAIN_SH +: IDX_W];
                if (!alu_res.no_borrow || (alu_res.sum[GRAIN_SH-1:0] != '0))
                begin
                    res_st_next = STAT_BADFREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_F_READ;
                end
            end

            S_F_READ:
            begin
                state_next = S_F_CHK;
            end

            S_F_CHK:
            begin
                if (!mem_rdata.is_start || mem_rdata.is_free)
                begin
                    res_st_next = STAT_BADFREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    hdr_next         = mem_rdata;
                    hdr_next.is_free = 1'b1;
                    moved_next       = 1'b0;
                    mem_req.raddr    = mem_rdata.prev_idx;
                    state_next       = mem_rdata.has_prev ? S_F_PCHK : S_F_NXT;
                end
            end

            S_F_PCHK:
            begin
                oth_next   = mem_rdata;
                state_next = mem_rdata.is_free ? S_F_PADD1 : S_F_NXT;
            end

            S_F_PADD1:
            begin
                alu_op.a   = ALU_W'(hdr_reg.size);
                alu_op.b   = ALU_W'(HEADER_BYTES);
                tmp_next   = alu_res.sum;
                state_next = S_F_PADD2;
            end

            S_F_PADD2:
            begin
                // fold this block into its free predecessor
                alu_op.a           = ALU_W'(oth_reg.size);
                alu_op.b           = tmp_reg;
                mem_req.we         = 1'b1;
                mem_req.waddr      = idx_reg;
                mem_req.wdata      = HDR_NONE;
                hdr_next           = oth_reg;
                hdr_next.size      = alu_res.sum[SIZE_W-1:0];
                hdr_next.has_next  = hdr_reg.has_next;
                hdr_next.next_idx  = hdr_reg.next_idx;
                idx_next           = hdr_reg.prev_idx;
                moved_next         = 1'b1;
                state_next         = S_F_NXT;
            end

            S_F_NXT:
            begin
                mem_req.raddr = hdr_reg.next_idx;
                state_next    = hdr_reg.has_next ? S_F_NCHK : S_F_WRW;
            end

            S_F_NCHK:
            begin
                oth_next = mem_rdata;
                if (mem_rdata.is_free)
                begin
                    state_next = S_F_NADD1;
                end
                else
                begin
                    wr_hdr.prev_idx = idx_reg;
                    mem_req.we      = moved_reg;
                    mem_req.waddr   = hdr_reg.next_idx;
                    mem_req.wdata   = wr_hdr;
                    state_next      = S_F_WRW;
                end
            end

            S_F_NADD1:
            begin
                alu_op.a   = ALU_W'(oth_reg.size);
                alu_op.b   = ALU_W'(HEADER_BYTES);
                tmp_next   = alu_res.sum;
                state_next = S_F_NADD2;
            end

            S_F_NADD2:
            begin
                // absorb the free successor
                alu_op.a      = ALU_W'(hdr_reg.size);
                alu_op.b      = tmp_reg;
                mem_req.we    = 1'b1;
                mem_req.waddr = hdr_reg.next_idx;
                mem_req.wdata = HDR_NONE;
                mem_req.raddr = oth_reg.next_idx;
                hdr_next.size = alu_res.sum[SIZE_W-1:0];
                if (oth_reg.has_next)
                begin
                    hdr_next.next_idx = oth_reg.next_idx;
                    state_next        = S_F_WRNN;
                end
                else
                begin
                    hdr_next.has_next = 1'b0;
                    state_next        = S_F_WRW;
                end
            end

            S_F_WRNN:
            begin
                wr_hdr.prev_idx = idx_reg;
                mem_req.we      = 1'b1;
                mem_req.waddr   = hdr_reg.next_idx;
                mem_req.wdata   = wr_hdr;
                state_next      = S_F_WRW;
            end

            S_F_WRW:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                mem_req.wdata = hdr_reg;
                res_off_next  = '0;
                res_st_next   = STAT_OK;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = res_off_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.result_offset = out_off_reg;
    assign rsp.status        = out_st_reg;

endmodule

// ===== design/first_fit_heap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top - first-fit heap allocator with coalescing
//
// Usage:
//   req channel (sink): one beat per command. command 0 allocates
//   request_size bytes (rounded up to 8), command 1 frees the user area at
//   user_offset. rsp channel (source): exactly one beat per command with
//   result_offset and status (0 ok, 1 zero size, 2 no space, 3 null free,
//   4 double or invalid free).
//   The heap is a 16 KiB region of 8-byte granules; each block header lives
//   in a 2048-entry header store, one header read and one write per cycle.
//   Allocate walks the chain from the first block; the walk loop (header
//   read, size compare on the shared adder) sets the allocate rate. A fit
//   is marked used; a split first writes the free remainder and relinks
//   its successor. Free merges with a free predecessor and successor. Zero
//   size and null pointer finish at once, a misaligned or short pointer
//   after the pointer subtract. A last step loads the result register.
//   Reset: a clearing pass writes all 2048 headers, the first as one free
//   block spanning the region, while req.ready stays low.
//   Stall: a finished result waits in the output register; the next command
//   is accepted meanwhile and finishes when that register empties.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top
    import ffha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp
);

    mem_req_t mem_req;
    hdr_t     mem_rdata;
    alu_op_t  alu_op;
    alu_res_t alu_res;

    // sequencer: walks the chain and owns both channels
    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .alu_op    (alu_op),
        .alu_res   (alu_res)
    );

    // header store, one access of each kind per cycle
    ffha_hdr_ram u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (mem_rdata)
    );

    // single adder shared by rounding, size compares, merges and offsets
    ffha_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

endmodule

// ===== design/ffha_checker.sv =====
// ----------------------------------------------------------------------------
// ffha_checker - port-level checks of the heap allocator
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module ffha_checker
    import ffha_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [13:0] result_offset,
    input logic [2:0]  status
);

    // a waiting result beat holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_offset) && $stable(status))
        else $error("result beat changed while stalled");

    // any non-ok status carries a zero offset
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != STAT_OK) |-> result_offset == '0)
        else $error("error status with nonzero offset");

    // one command at a time: busy right after a beat is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // allocated offsets sit past a header and on a granule
    a_ok_align: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_OK) && (result_offset != '0) |->
        (result_offset >= 14'(HEADER_BYTES)) && (result_offset[2:0] == 3'b000))
        else $error("misaligned allocation offset");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .result_offset (rsp.result_offset),
    .status        (rsp.status)
);

// ===== bench/tb_first_fit_heap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_top - self-checking bench for the heap allocator
// Drives allocate and free commands with random gaps and response stalls. A
// model of the block list, run on every accepted command, predicts each
// response, and the bench compares it field by field.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_top;
    import ffha_pkg::*;

    // How a free command finds its pointer: as queued, or drawn when the beat
    // is presented from the buffers that are live or were freed recently.
    typedef enum logic [1:0] {
        PTR_GIVEN,
        PTR_LIVE,
        PTR_FREED
    } ptr_pick_t;

    typedef struct packed {
        cmd_t              command;
        logic [REQ_W-1:0]  request_size;
        logic [OFF_W-1:0]  user_offset;
        ptr_pick_t         pick;
    } heap_cmd_t;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        status_t          status;
    } heap_result_t;

    localparam int RANDOM_CMDS = 1100;
    localparam int FREED_KEEP  = 32;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Bench-side copies of every input, known from time zero.
    logic             drv_valid   = 1'b0;
    logic             drv_command = 1'b0;
    logic [REQ_W-1:0] drv_size    = '0;
    logic [OFF_W-1:0] drv_offset  = '0;
    logic             drv_ready   = 1'b0;

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();

    assign req_ch.valid        = drv_valid;
    assign req_ch.command      = drv_command;
    assign req_ch.request_size = drv_size;
    assign req_ch.user_offset  = drv_offset;
    assign rsp_ch.ready        = drv_ready;

    first_fit_heap_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Block list model: one entry per byte offset, as the chain of headers.
    // ------------------------------------------------------------------------
    int unsigned blk_size [REGION_BYTES];
    int unsigned blk_prev [REGION_BYTES];
    int unsigned blk_next [REGION_BYTES];
    bit          blk_start[REGION_BYTES];
    bit          blk_free [REGION_BYTES];
    bit          blk_hprev[REGION_BYTES];
    bit          blk_hnext[REGION_BYTES];

    heap_cmd_t        cmd_backlog[$];
    heap_result_t     owed_results[$];
    logic [OFF_W-1:0] live_bufs[$];
    logic [OFF_W-1:0] freed_bufs[$];

    int unsigned mismatches = 0;
    int unsigned rsp_beats  = 0;

    bit          req_busy  = 1'b0;
    bit          req_taken = 1'b0;
    bit          rsp_taken = 1'b0;
    int unsigned req_gap   = 0;
    int unsigned rsp_hold  = 0;
    int unsigned req_calm  = 0;
    int unsigned rsp_calm  = 0;

    function automatic void heap_reset();
        for (int i = 0; i < REGION_BYTES; i++)
        begin
            blk_size[i]  = 0;
            blk_prev[i]  = 0;
            blk_next[i]  = 0;
            blk_start[i] = 1'b0;
            blk_free[i]  = 1'b0;
            blk_hprev[i] = 1'b0;
            blk_hnext[i] = 1'b0;
        end
        // One free block spans the whole region.
        blk_start[0] = 1'b1;
        blk_free[0]  = 1'b1;
        blk_size[0]  = REGION_BYTES - HEADER_BYTES;
    endfunction

    function automatic void heap_alloc(input logic [REQ_W-1:0] req,
                                       output logic [OFF_W-1:0] off,
                                       output status_t st);
        int unsigned need;
        int unsigned cur;
        int unsigned nb;
        bit          done;
        off  = '0;
        need = ((int'(req) + 7) / 8) * 8;
        if (req == 0)
        begin
            st = STAT_ZERO;
            return;
        end
        st   = STAT_NOSPACE;
        cur  = 0;
        done = 1'b0;
        // Walk from the first block; take the first free block that fits.
        for (int guard = 0; guard < REGION_BYTES && !done; guard++)
        begin
            if (blk_free[cur] && blk_size[cur] >= need)
            begin
                // Split only when more than one header is left over.
                if (blk_size[cur] > need + HEADER_BYTES)
                begin
                    nb = cur + need + HEADER_BYTES;
                    blk_size[nb]  = blk_size[cur] - (need + HEADER_BYTES);
                    blk_start[nb] = 1'b1;
                    blk_free[nb]  = 1'b1;
                    blk_hprev[nb] = 1'b1;
                    blk_hnext[nb] = blk_hnext[cur];
                    blk_prev[nb]  = cur;
                    blk_next[nb]  = blk_next[cur];
                    if (blk_hnext[cur])
                        blk_prev[blk_next[cur]] = nb;
                    blk_next[cur]  = nb;
                    blk_hnext[cur] = 1'b1;
                    blk_size[cur]  = need;
                end
                blk_free[cur] = 1'b0;
                st   = STAT_OK;
                off  = OFF_W'(cur + HEADER_BYTES);
                done = 1'b1;
            end
            else if (!blk_hnext[cur])
                done = 1'b1;
            else
                cur = blk_next[cur];
        end
    endfunction

    function automatic status_t heap_release(input logic [OFF_W-1:0] uoff);
        int unsigned b;
        int unsigned p;
        int unsigned n;
        if (uoff == 0)
            return STAT_NULL;
        if (uoff < HEADER_BYTES)
            return STAT_BADFREE;
        b = uoff - HEADER_BYTES;
        if (b >= REGION_BYTES)
            return STAT_BADFREE;
        if (!blk_start[b] || blk_free[b])
            return STAT_BADFREE;

        blk_free[b] = 1'b1;

        // Fold into a free previous block.
        if (blk_hprev[b])
        begin
            p = blk_prev[b];
            if (blk_free[p])
            begin
                blk_size[p]  = blk_size[p] + blk_size[b] + HEADER_BYTES;
                blk_next[p]  = blk_next[b];
                blk_hnext[p] = blk_hnext[b];
                if (blk_hnext[b])
                    blk_prev[blk_next[b]] = p;
                blk_start[b] = 1'b0;
                blk_free[b]  = 1'b0;
                blk_hprev[b] = 1'b0;
                blk_hnext[b] = 1'b0;
                b = p;
            end
        end

        // Absorb a free next block.
        if (blk_hnext[b])
        begin
            n = blk_next[b];
            if (blk_free[n])
            begin
                blk_size[b] = blk_size[b] + blk_size[n] + HEADER_BYTES;
                if (blk_hnext[n])
                begin
                    blk_next[b] = blk_next[n];
                    blk_prev[blk_next[n]] = b;
                end
                else
                    blk_hnext[b] = 1'b0;
                blk_start[n] = 1'b0;
                blk_free[n]  = 1'b0;
                blk_hprev[n] = 1'b0;
                blk_hnext[n] = 1'b0;
            end
        end
        return STAT_OK;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Idle length for one beat: often none, sometimes a calm stretch of
    // back-to-back beats.
    function automatic int unsigned idle_draw(inout int unsigned calm);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            calm = $urandom_range(8, 40);
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
    endfunction

    function automatic void queue_cmd(input cmd_t op, input logic [REQ_W-1:0] sz,
                                      input logic [OFF_W-1:0] off,
                                      input ptr_pick_t pick);
        heap_cmd_t c;
        c.command      = op;
        c.request_size = sz;
        c.user_offset  = off;
        c.pick         = pick;
        cmd_backlog.push_back(c);
    endfunction

    // ------------------------------------------------------------------------
    // Rising edge: predict every accepted command beat, check every response
    // beat against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        heap_result_t got;
        heap_result_t want;
        int           hit;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            if (req_ch.command == CMD_ALLOC)
                heap_alloc(req_ch.request_size, got.offset, got.status);
            else
            begin
                got.offset = '0;
                got.status = heap_release(req_ch.user_offset);
            end
            owed_results.push_back(got);

            // Track which buffers are live so later frees can target them.
            if (got.status == STAT_OK && req_ch.command == CMD_ALLOC)
                live_bufs.push_back(got.offset);
            else if (got.status == STAT_OK)
            begin
                hit = -1;
                foreach (live_bufs[i])
                    if (live_bufs[i] == req_ch.user_offset)
                        hit = i;
                if (hit >= 0)
                    live_bufs.delete(hit);
                freed_bufs.push_back(req_ch.user_offset);
                if (freed_bufs.size() > FREED_KEEP)
                    void'(freed_bufs.pop_front());
            end
            req_taken = 1'b1;
        end

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_beats++;
            if (owed_results.size() == 0)
                flag_mismatch($sformatf("response beat %0d with no command outstanding",
                                        rsp_beats));
            else
            begin
                want = owed_results.pop_front();
                if (rsp_ch.result_offset !== want.offset)
                    flag_mismatch($sformatf("beat %0d result_offset %0d, expected %0d",
                                            rsp_beats, rsp_ch.result_offset, want.offset));
                if (rsp_ch.status !== want.status)
                    flag_mismatch($sformatf("beat %0d status %0d, expected %0d (%s)",
                                            rsp_beats, rsp_ch.status, want.status,
                                            want.status.name()));
            end
            rsp_taken = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Command driver: change inputs on the falling edge. Hold a beat until it
    // is taken, then idle for the drawn gap before presenting the next one.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        heap_cmd_t nxt;
        if (rst_n)
        begin
            if (req_taken)
            begin
                req_taken = 1'b0;
                req_busy  = 1'b0;
            end
            if (!req_busy)
            begin
                if (req_gap != 0)
                    req_gap--;
                else if (cmd_backlog.size() != 0)
                begin
                    nxt = cmd_backlog.pop_front();
                    // Resolve the pointer now: every earlier beat has been
                    // taken, so the live and freed lists are current.
                    if (nxt.pick == PTR_LIVE)
                    begin
                        if (live_bufs.size() != 0)
                            nxt.user_offset =
                                live_bufs[$urandom_range(0, live_bufs.size() - 1)];
                        else
                        begin
                            // Nothing to free; allocate a small buffer instead.
                            nxt.command      = CMD_ALLOC;
                            nxt.request_size = REQ_W'($urandom_range(1, 64));
                        end
                    end
                    else if (nxt.pick == PTR_FREED)
                    begin
                        if (freed_bufs.size() != 0)
                            nxt.user_offset =
                                freed_bufs[$urandom_range(0, freed_bufs.size() - 1)];
                        else
                            nxt.user_offset = OFF_W'($urandom);
                    end
                    drv_command <= nxt.command;
                    drv_size    <= nxt.request_size;
                    drv_offset  <= nxt.user_offset;
                    req_busy = 1'b1;
                    req_gap  = idle_draw(req_calm);
                end
            end
            drv_valid <= req_busy;
        end
    end

    // ------------------------------------------------------------------------
    // Response side: after each beat, drop ready for a drawn number of cycles
    // in which a response is actually waiting.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
            begin
                rsp_taken = 1'b0;
                rsp_hold  = idle_draw(rsp_calm);
            end
            if (rsp_hold != 0 && rsp_ch.valid)
                rsp_hold--;
            drv_ready <= (rsp_hold == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned alloc_pct;
        int unsigned roll;
        int unsigned settle;
        logic [REQ_W-1:0] sz;

        heap_reset();

        // Directed part. Offsets assume the chain built by the beats before.
        queue_cmd(CMD_FREE,  16'h0000, 14'd0,     PTR_GIVEN); // null pointer
        queue_cmd(CMD_FREE,  16'hFFFF, 14'd32,    PTR_GIVEN); // region block is free
        queue_cmd(CMD_FREE,  16'h0000, 14'd5,     PTR_GIVEN); // below one header
        queue_cmd(CMD_FREE,  16'h0000, 14'd33,    PTR_GIVEN); // not a block start
        queue_cmd(CMD_FREE,  16'h0000, 14'h3FFF,  PTR_GIVEN); // top of the offset range
        queue_cmd(CMD_ALLOC, 16'd0,    14'h3FFF,  PTR_GIVEN); // zero size
        queue_cmd(CMD_ALLOC, 16'hFFFF, 14'h3FFF,  PTR_GIVEN); // far beyond the region
        queue_cmd(CMD_ALLOC, 16'd16353, 14'd0,    PTR_GIVEN); // rounds past the region
        queue_cmd(CMD_ALLOC, 16'd16352, 14'd0,    PTR_GIVEN); // exact fit, whole heap
        queue_cmd(CMD_ALLOC, 16'd1,    14'd0,     PTR_GIVEN); // heap full
        queue_cmd(CMD_FREE,  16'd0,    14'd32,    PTR_GIVEN);
        queue_cmd(CMD_ALLOC, 16'd16330, 14'd0,    PTR_GIVEN); // near fit, no split
        queue_cmd(CMD_FREE,  16'd0,    14'd32,    PTR_GIVEN);
        queue_cmd(CMD_ALLOC, 16'd1,    14'd0,     PTR_GIVEN); // split, rounds to 8
        queue_cmd(CMD_ALLOC, 16'd8,    14'd0,     PTR_GIVEN);
        queue_cmd(CMD_ALLOC, 16'd100,  14'd0,     PTR_GIVEN);
        queue_cmd(CMD_ALLOC, 16'd16,   14'd0,     PTR_GIVEN);
        queue_cmd(CMD_FREE,  16'd0,    14'd72,    PTR_GIVEN); // both neighbours in use
        queue_cmd(CMD_FREE,  16'd0,    14'd72,    PTR_GIVEN); // double free
        queue_cmd(CMD_FREE,  16'd0,    14'd248,   PTR_GIVEN); // merge with free tail
        queue_cmd(CMD_FREE,  16'd0,    14'd32,    PTR_GIVEN); // merge with free next
        queue_cmd(CMD_FREE,  16'd0,    14'd112,   PTR_GIVEN); // merge on both sides
        queue_cmd(CMD_ALLOC, 16'd16352, 14'd0,    PTR_GIVEN); // heap whole again
        queue_cmd(CMD_FREE,  16'd0,    14'd32,    PTR_GIVEN);

        // Random part: phases lean toward filling or draining the heap so the
        // chain grows long and then collapses through merges.
        alloc_pct = 60;
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 100 == 0)
                alloc_pct = $urandom_range(25, 85);
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                // Noise: raw fields, zero sizes, null pointers.
                case ($urandom_range(0, 3))
                    0: queue_cmd(CMD_ALLOC, 16'd0, OFF_W'($urandom), PTR_GIVEN);
                    1: queue_cmd(CMD_FREE, REQ_W'($urandom), 14'd0, PTR_GIVEN);
                    default: queue_cmd(cmd_t'($urandom_range(0, 1)), REQ_W'($urandom),
                                       OFF_W'($urandom), PTR_GIVEN);
                endcase
            end
            else if (roll < 13)
                queue_cmd(CMD_FREE, REQ_W'($urandom), 14'd0, PTR_FREED);
            else if ($urandom_range(0, 99) < alloc_pct)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: sz = REQ_W'($urandom_range(1, 64));
                    6, 7:             sz = REQ_W'($urandom_range(65, 512));
                    8:                sz = REQ_W'($urandom_range(513, 4096));
                    default:          sz = REQ_W'($urandom_range(4097, 16352));
                endcase
                queue_cmd(CMD_ALLOC, sz, OFF_W'($urandom), PTR_GIVEN);
            end
            else
                queue_cmd(CMD_FREE, REQ_W'($urandom), 14'd0, PTR_LIVE);
        end

        // Hold reset, then release it on a falling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every command beat to be taken.
        while (cmd_backlog.size() != 0 || req_busy)
            @(posedge clk);

        // Drain the responses, bounded well past the longest walk.
        settle = 0;
        while (owed_results.size() != 0 && settle < 20000)
        begin
            @(posedge clk);
            settle++;
        end
        if (owed_results.size() != 0)
            flag_mismatch($sformatf("%0d responses never arrived", owed_results.size()));

        // Watch a while longer for stray response beats.
        repeat (64) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #60000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
design/ffha_pkg.sv
design/ffha_if.sv
design/ffha_hdr_ram.sv
design/ffha_alu.sv
design/ffha_ctrl.sv
design/first_fit_heap_allocator_top.sv
design/ffha_checker.sv
bench/tb_first_fit_heap_allocator_top.sv
